// ----- hw/rtl/fsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants
// Item structs, operation and status codes, and controller commands for the
// free slot cache with spill.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int DEF_CACHE_DEPTH = 64;
  localparam int DEF_INDEX_BITS  = 32;

  localparam logic [1:0] OP_FREE   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_ALLOC  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] entry_index;
    logic        link_present;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_index;
    logic        out_valid;
    logic [1:0]  status;
    logic [6:0]  held_count;
    logic [31:0] total_free;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } fsc_cmd_t;

endpackage

// ----- hw/rtl/fsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// fsc_ctrl: sequencing controller
// Takes one item at a time, waits in S_RESP for the registered ring read, then
// commits the operation into the output register once it is free.
// ----------------------------------------------------------------------------
module fsc_ctrl
  import fsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output fsc_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.commit = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_RESP))
    else $error("accepted item did not move to response");
  a_commit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid_r && state_r == S_IDLE))
    else $error("commit did not present a result");
  a_rise_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result appeared without a pending item");
`endif

endmodule

// ----- hw/rtl/fsc_dp.sv -----
// ----------------------------------------------------------------------------
// fsc_dp: ring datapath
// Ring memory of free slot indices, front pointer, held count, saturating
// free total and the output register.
// ----------------------------------------------------------------------------
module fsc_dp
  import fsc_pkg::*;
#(
  parameter int CACHE_DEPTH = DEF_CACHE_DEPTH,
  parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  fsc_cmd_t  cmd,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  localparam int PW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CW = $clog2(CACHE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_POS  = PW'(CACHE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(CACHE_DEPTH);
  localparam logic [PW:0]   DEPTH_EXT = (PW + 1)'(CACHE_DEPTH);

  logic [INDEX_BITS-1:0] ring_mem [CACHE_DEPTH];

  logic [PW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [31:0]           total_r, total_nxt;
  logic [1:0]            op_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic                  link_r;
  logic [INDEX_BITS-1:0] rd_data_r;
  out_item_t             out_r, out_nxt;

  logic [PW-1:0]         front_dec, front_inc, back_pos, rd_addr, wr_addr;
  logic [PW:0]           back_sum;
  logic                  full, wr_en;

  assign full      = (count_r == FULL_CNT);
  assign front_dec = (front_r == '0) ? LAST_POS : front_r - 1'b1;
  assign front_inc = (front_r == LAST_POS) ? '0 : front_r + 1'b1;
  assign back_sum  = {1'b0, front_r} + (PW + 1)'(count_r);
  assign back_pos  = (back_sum >= DEPTH_EXT) ? PW'(back_sum - DEPTH_EXT) : PW'(back_sum);
  assign rd_addr   = (in_data.opcode == OP_FREE) ? front_dec : front_r;

  always_comb begin
    front_nxt           = front_r;
    count_nxt           = count_r;
    total_nxt           = total_r;
    wr_en               = 1'b0;
    wr_addr             = front_dec;
    out_nxt.out_index   = '0;
    out_nxt.out_valid   = 1'b0;
    out_nxt.status      = ST_OK;
    case (op_r)
      OP_FREE: begin
        wr_en     = 1'b1;
        wr_addr   = front_dec;
        front_nxt = front_dec;
        if (full) begin
          out_nxt.out_index = 32'(rd_data_r);
          out_nxt.out_valid = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
        end
        if (total_r != TOTAL_MAX) begin
          total_nxt = total_r + 1'b1;
        end
      end
      OP_APPEND: begin
        if (link_r) begin
          if (full) begin
            out_nxt.status = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = back_pos;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      OP_ALLOC: begin
        if (count_r == '0) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.out_index = 32'(rd_data_r);
          out_nxt.out_valid = 1'b1;
          front_nxt         = front_inc;
          count_nxt         = count_r - 1'b1;
          if (total_r != '0) begin
            total_nxt = total_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    out_nxt.held_count = 7'(count_nxt);
    out_nxt.total_free = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data_r <= ring_mem[rd_addr];
    end
    if (cmd.commit && wr_en) begin
      ring_mem[wr_addr] <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_data.opcode;
      idx_r  <= INDEX_BITS'(in_data.entry_index);
      link_r <= in_data.link_present;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      total_r <= '0;
    end else if (cmd.commit) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
  end

  assign out_data = out_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("held count above cache depth");
  a_alloc_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && op_r == OP_ALLOC && count_r != '0)
      |=> (count_r == $past(count_r) - 1'b1))
    else $error("allocate did not pop one entry");
  a_spill_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && op_r == OP_FREE && full) |=> (full && out_r.out_valid))
    else $error("free into full cache did not spill");
`endif

endmodule

// ----- hw/rtl/free_slot_cache_with_spill_core.sv -----
// ----------------------------------------------------------------------------
// free_slot_cache_with_spill_core: free slot cache with spill
// Usage:
//   in_valid/in_ready carry one operation item in in_data: free (push the
//   index at the front), append link (push a spilled index at the back) or
//   allocate (pop the front index).
//   out_valid/out_ready carry exactly one result item per operation in
//   out_data: allocated or spilled index, status, held count and the
//   saturating total of free slots.
//   From acceptance, the ring memory read is registered first; the commit
//   step then updates the cache and loads the output register.
//   The block works on one item at a time; the controller takes a new
//   item only after the last commits.
//   A new item may be accepted while the previous result still waits.
//   If the receiver stalls, the next result waits in its commit step and
//   in_ready stays low until the output register frees.
//   Reset empties the cache and clears the free total; ring contents are
//   left as they are and are never used before being written.
// ----------------------------------------------------------------------------
module free_slot_cache_with_spill_core
  import fsc_pkg::*;
#(
  parameter int CACHE_DEPTH = DEF_CACHE_DEPTH,
  parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  fsc_cmd_t cmd;

  fsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  fsc_dp #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
